[rtl/core/bdra_pkg.sv]
// shared constants and types of the bounded-denominator rational approximation core
package bdra_pkg;

  // default geometry
  localparam int unsigned DENOM_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 32;

  // result word layout
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_TDATA_W = ((2 * OUT_W + STATUS_W + 7) / 8) * 8;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2
  } status_e;

  // flags of the shared add/subtract unit
  typedef struct packed {
    logic borrow;
    logic zero;
  } alu_flags_t;

endpackage

[rtl/core/bounded_denominator_rational_approx_core.sv]
// top level of the bounded-denominator rational approximation core
//
// Input stream: each word carries a value x in unsigned Q1.FRAC_BITS and a
// largest denominator n. Output stream: one word per input, the fraction p/q
// with q <= n nearest to x along the Stern-Brocot walk, and a status code
// (ok, value above one, order zero; errors give 0/0).
// An input word is taken only while the core is idle. Out-of-range inputs and
// the exact values zero and one go from idle straight to the result. Otherwise
// the core scales the errors by n(n+1) with a serial shift-add multiply, runs
// each mediant step through the test, update and check states on the shared
// wide adder, and picks the closer bound with two more serial shift-add
// products. The walk takes fewer mediant steps than max_denominator, and
// this step loop sets the worst case of the work per input word.
// The result sits in an output register; the core takes the next input word
// while it waits, and stalls only if a second result is ready before the
// first is taken. Reset empties the output register and returns to idle.
module bounded_denominator_rational_approx_core
  import bdra_pkg::*;
#(
  parameter int unsigned DENOM_BITS = DENOM_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  localparam int unsigned IN_TDATA_W = ((FRAC_BITS + 1 + DENOM_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // real_value [FRAC_BITS:0], max_denominator above it, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // numerator [15:0], denominator [31:16], status [33:32], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                  res_valid, res_ready, load;
  logic [DENOM_BITS-1:0] res_num, res_den;
  status_e               res_status;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  bdra_seq #(
    .DENOM_BITS (DENOM_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata[FRAC_BITS:0]),
    .in_order_i   (s_axis_tdata[FRAC_BITS+DENOM_BITS:FRAC_BITS+1]),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_num_o    (res_num),
    .res_den_o    (res_den),
    .res_status_o (res_status)
  );

  // output register fills when empty or being drained
  assign res_ready   = ~out_valid_q | m_axis_tready;
  assign load        = res_valid & res_ready;
  assign out_valid_d = load | (out_valid_q & ~m_axis_tready);
  assign out_data_d  = load ? OUT_TDATA_W'({res_status, OUT_W'(res_den), OUT_W'(res_num)})
                            : out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/core/bdra_alu.sv]
// shared wide add/subtract unit with borrow and zero flags
module bdra_alu
  import bdra_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] res_o,
  output alu_flags_t   flags_o
);

  logic [W:0] sum;
  logic [W-1:0] b_inv;

  // a + b or a - b through one adder with carry in
  assign b_inv = sub_i ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_inv} + (W+1)'(sub_i);
  assign res_o = sum[W-1:0];

  // borrow means a < b on a subtract
  assign flags_o.borrow = sub_i & ~sum[W];
  assign flags_o.zero   = (sum[W-1:0] == '0);

endmodule

[rtl/core/bdra_seq.sv]
// sequencer and datapath registers of the mediant walk around the shared unit
module bdra_seq
  import bdra_pkg::*;
#(
  parameter int unsigned DENOM_BITS = DENOM_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [FRAC_BITS:0]    in_value_i,
  input  logic [DENOM_BITS-1:0] in_order_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [DENOM_BITS-1:0] res_num_o,
  output logic [DENOM_BITS-1:0] res_den_o,
  output status_e               res_status_o
);

  // scaled error width, accumulator width, n(n+1) width, counter width
  localparam int unsigned W_E   = FRAC_BITS + 1 + 2 * DENOM_BITS;
  localparam int unsigned W_ACC = W_E + DENOM_BITS + 1;
  localparam int unsigned NN_W  = 2 * DENOM_BITS;
  localparam int unsigned CNT_W = $clog2(NN_W + 1);

  localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_INITC = 9'b000000100,
    S_STEP  = 9'b000001000,
    S_UPD   = 9'b000010000,
    S_CHK   = 9'b000100000,
    S_FMA   = 9'b001000000,
    S_FMS   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [DENOM_BITS-1:0] a_q, a_d, b_q, b_d, c_q, c_d, d_q, d_d, n_q, n_d;
  logic [NN_W-1:0]       nn_q, nn_d, mplier_q, mplier_d;
  logic [W_E-1:0]        ea_q, ea_d, ec_q, ec_d;
  logic [W_ACC-1:0]      acc_q, acc_d, mcand_q, mcand_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  dir_q, dir_d;
  logic [DENOM_BITS-1:0] res_num_q, res_num_d, res_den_q, res_den_d;
  status_e               res_status_q, res_status_d;

  logic [W_ACC-1:0]      alu_a, alu_b, alu_res;
  logic                  alu_sub;
  alu_flags_t            alu_flags;

  logic [DENOM_BITS:0]   p_w, q_w, n_inc;
  logic [NN_W-1:0]       nn_w;
  logic [DENOM_BITS-1:0] q_new;
  logic                  last_bit;

  bdra_alu #(
    .W (W_ACC)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  // mediant and order terms
  assign p_w      = {1'b0, a_q} + {1'b0, c_q};
  assign q_w      = {1'b0, b_q} + {1'b0, d_q};
  assign n_inc    = {1'b0, in_order_i} + (DENOM_BITS+1)'(1);
  assign nn_w     = NN_W'(in_order_i) * NN_W'(n_inc);
  assign q_new    = dir_q ? b_q : d_q;
  assign last_bit = (cnt_q == CNT_W'(1));

  // next state and datapath
  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    c_d          = c_q;
    d_d          = d_q;
    n_d          = n_q;
    nn_d         = nn_q;
    mplier_d     = mplier_q;
    ea_d         = ea_q;
    ec_d         = ec_q;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    cnt_d        = cnt_q;
    dir_d        = dir_q;
    res_num_d    = res_num_q;
    res_den_d    = res_den_q;
    res_status_d = res_status_q;
    alu_a        = acc_q;
    alu_b        = mplier_q[0] ? mcand_q : '0;
    alu_sub      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_num_d    = '0;
          res_den_d    = '0;
          res_status_d = ST_OK;
          if (in_value_i > ONE_FX) begin
            res_status_d = ST_RANGE;
            state_d      = S_DONE;
          end else if (in_order_i == '0) begin
            res_status_d = ST_ORDER;
            state_d      = S_DONE;
          end else if (in_value_i == '0) begin
            res_den_d = DENOM_BITS'(1);
            state_d   = S_DONE;
          end else if (in_value_i == ONE_FX) begin
            res_num_d = DENOM_BITS'(1);
            res_den_d = DENOM_BITS'(1);
            state_d   = S_DONE;
          end else begin
            a_d      = '0;
            b_d      = DENOM_BITS'(1);
            c_d      = DENOM_BITS'(1);
            d_d      = DENOM_BITS'(1);
            n_d      = in_order_i;
            nn_d     = nn_w;
            mplier_d = nn_w;
            acc_d    = '0;
            mcand_d  = W_ACC'(in_value_i);
            cnt_d    = CNT_W'(NN_W);
            state_d  = S_MUL;
          end
        end
      end

      // lower error scaled by n(n+1), one shift-add a cycle
      S_MUL: begin
        acc_d    = alu_res;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CNT_W'(1);
        if (last_bit) begin
          ea_d    = alu_res[W_E-1:0];
          state_d = S_INITC;
        end
      end

      // upper error is one * n(n+1) minus the lower error
      S_INITC: begin
        alu_a   = W_ACC'(nn_q) << FRAC_BITS;
        alu_b   = W_ACC'(ea_q);
        alu_sub = 1'b1;
        ec_d    = alu_res[W_E-1:0];
        state_d = S_STEP;
      end

      // mediant side test, or leave when its denominator is too large
      S_STEP: begin
        alu_a   = W_ACC'(ea_q);
        alu_b   = W_ACC'(ec_q);
        alu_sub = 1'b1;
        dir_d   = ~alu_flags.borrow & ~alu_flags.zero;
        if (q_w > {1'b0, n_q}) begin
          acc_d    = '0;
          mcand_d  = W_ACC'(ea_q);
          mplier_d = NN_W'(d_q);
          cnt_d    = CNT_W'(DENOM_BITS);
          state_d  = S_FMA;
        end else begin
          state_d = S_UPD;
        end
      end

      // move one bound to the mediant and update its error
      S_UPD: begin
        alu_sub = 1'b1;
        if (dir_q) begin
          alu_a = W_ACC'(ea_q);
          alu_b = W_ACC'(ec_q);
          ea_d  = alu_res[W_E-1:0];
          a_d   = p_w[DENOM_BITS-1:0];
          b_d   = q_w[DENOM_BITS-1:0];
        end else begin
          alu_a = W_ACC'(ec_q);
          alu_b = W_ACC'(ea_q);
          ec_d  = alu_res[W_E-1:0];
          c_d   = p_w[DENOM_BITS-1:0];
          d_d   = q_w[DENOM_BITS-1:0];
        end
        state_d = S_CHK;
      end

      // close enough once the error is below one * q
      S_CHK: begin
        alu_a   = dir_q ? W_ACC'(ea_q) : W_ACC'(ec_q);
        alu_b   = W_ACC'(q_new) << FRAC_BITS;
        alu_sub = 1'b1;
        if (alu_flags.borrow) begin
          acc_d    = '0;
          mcand_d  = W_ACC'(ea_q);
          mplier_d = NN_W'(d_q);
          cnt_d    = CNT_W'(DENOM_BITS);
          state_d  = S_FMA;
        end else begin
          state_d = S_STEP;
        end
      end

      // accumulate lower error times d
      S_FMA: begin
        acc_d    = alu_res;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CNT_W'(1);
        if (last_bit) begin
          mcand_d  = W_ACC'(ec_q);
          mplier_d = NN_W'(b_q);
          cnt_d    = CNT_W'(DENOM_BITS);
          state_d  = S_FMS;
        end
      end

      // subtract upper error times b, pick upper bound if strictly closer
      S_FMS: begin
        alu_sub  = 1'b1;
        acc_d    = alu_res;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q - CNT_W'(1);
        if (last_bit) begin
          if (~alu_res[W_ACC-1] & ~alu_flags.zero) begin
            res_num_d = c_q;
            res_den_d = d_q;
          end else begin
            res_num_d = a_q;
            res_den_d = b_q;
          end
          res_status_d = ST_OK;
          state_d      = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    c_q          <= c_d;
    d_q          <= d_d;
    n_q          <= n_d;
    nn_q         <= nn_d;
    mplier_q     <= mplier_d;
    ea_q         <= ea_d;
    ec_q         <= ec_d;
    acc_q        <= acc_d;
    mcand_q      <= mcand_d;
    cnt_q        <= cnt_d;
    dir_q        <= dir_d;
    res_num_q    <= res_num_d;
    res_den_q    <= res_den_d;
    res_status_q <= res_status_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);
  assign res_num_o    = res_num_q;
  assign res_den_o    = res_den_q;
  assign res_status_o = res_status_q;

  // bounds never pass the order during the walk
  a_step_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) |-> (b_q <= n_q && d_q <= n_q && b_q != '0 && d_q != '0))
    else $error("bound denominator out of range during walk");

  // a good answer is a proper fraction with a nonzero denominator
  a_ok_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && res_status_q == ST_OK) |->
      (res_den_q != '0 && res_num_q <= res_den_q))
    else $error("ok result is not a proper fraction");

  // serial multiply never runs with an empty counter
  a_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_FMA || state_q == S_FMS) |-> (cnt_q != '0))
    else $error("shift-add counter ran out");

  // an accepted word always starts work
  a_accept_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q != S_IDLE))
    else $error("accepted word did not leave idle");

endmodule

[sim/bdra_checker.sv]
// stream monitor and fraction predictor for the rational approximation core
`timescale 1ns / 100ps
module bdra_checker
  import bdra_pkg::*;
#(
  parameter int unsigned IN_W = ((FRAC_BITS_DEF + 1 + DENOM_BITS_DEF + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // real_value, max_denominator, zero fill
  input  logic [IN_W-1:0]        s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // numerator, denominator, status, zero fill
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned            mismatch_count_o,
  output int unsigned            fractions_owed_o,
  output int unsigned            fractions_seen_o
);

  typedef struct packed {
    logic [OUT_W-1:0] numerator;
    logic [OUT_W-1:0] denominator;
    status_e          status;
  } fraction_t;

  fraction_t owed_fractions[$];

  // mediant walk between 0/1 and 1/1 with exact cross-products, closer bound wins
  function automatic fraction_t nearest_fraction(input logic [FRAC_BITS_DEF:0] x,
                                                 input logic [DENOM_BITS_DEF-1:0] n);
    logic [127:0] one_w, x_w, n_w;
    logic [127:0] lo_p, lo_q, hi_p, hi_q, mid_p, mid_q;
    logic [127:0] mid_scaled, x_scaled, gap;
    bit           walking;
    fraction_t    r;
    one_w         = 128'd1 << FRAC_BITS_DEF;
    x_w           = 128'(x);
    n_w           = 128'(n);
    r.numerator   = '0;
    r.denominator = '0;
    r.status      = ST_OK;
    if (x_w > one_w) begin
      r.status = ST_RANGE;
    end else if (n_w == 0) begin
      r.status = ST_ORDER;
    end else if (x_w == 0) begin
      r.denominator = 1;
    end else if (x_w == one_w) begin
      r.numerator   = 1;
      r.denominator = 1;
    end else begin
      lo_p    = 0;
      lo_q    = 1;
      hi_p    = 1;
      hi_q    = 1;
      walking = 1'b1;
      while (walking) begin
        mid_p = lo_p + hi_p;
        mid_q = lo_q + hi_q;
        if (mid_q > n_w) begin
          walking = 1'b0;
        end else begin
          mid_scaled = mid_p * one_w;
          x_scaled   = x_w * mid_q;
          if (mid_scaled < x_scaled) begin
            lo_p = mid_p;
            lo_q = mid_q;
            gap  = x_scaled - mid_scaled;
          end else begin
            hi_p = mid_p;
            hi_q = mid_q;
            gap  = mid_scaled - x_scaled;
          end
          // close enough: error below 1/(n(n+1))
          if (gap * (n_w * (n_w + 1)) < one_w * mid_q) walking = 1'b0;
        end
      end
      // upper bound only when strictly closer, a tie keeps the lower one
      if ((hi_p * lo_q + lo_p * hi_q) * one_w < ((x_w * lo_q * hi_q) << 1)) begin
        r.numerator   = hi_p[OUT_W-1:0];
        r.denominator = hi_q[OUT_W-1:0];
      end else begin
        r.numerator   = lo_p[OUT_W-1:0];
        r.denominator = lo_q[OUT_W-1:0];
      end
    end
    return r;
  endfunction

  // check result words against the oldest owed fraction, then log new inputs
  always @(posedge clk_i) begin
    logic [OUT_W-1:0]    got_num, got_den;
    logic [STATUS_W-1:0] got_status;
    fraction_t           want;
    int unsigned         errs;
    if (rst_ni) begin
      errs = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        got_num    = m_axis_tdata[OUT_W-1:0];
        got_den    = m_axis_tdata[2*OUT_W-1:OUT_W];
        got_status = m_axis_tdata[2*OUT_W +: STATUS_W];
        fractions_seen_o <= fractions_seen_o + 1;
        if (owed_fractions.size() == 0) begin
          $error("unexpected result word: numerator %0d denominator %0d status %0d",
                 got_num, got_den, got_status);
          errs++;
        end else begin
          want = owed_fractions.pop_front();
          if (got_num !== want.numerator) begin
            $error("numerator: expected %0d, actual %0d", want.numerator, got_num);
            errs++;
          end
          if (got_den !== want.denominator) begin
            $error("denominator: expected %0d, actual %0d", want.denominator, got_den);
            errs++;
          end
          if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            errs++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_fractions.push_back(nearest_fraction(
            s_axis_tdata[FRAC_BITS_DEF:0],
            s_axis_tdata[FRAC_BITS_DEF+1 +: DENOM_BITS_DEF]));
      end
      mismatch_count_o <= mismatch_count_o + errs;
      fractions_owed_o <= owed_fractions.size();
    end
  end

endmodule

[sim/tb_bounded_denominator_rational_approx_core.sv]
// testbench top: clock, reset, stream stimulus and verdict for the approximation core
`timescale 1ns / 100ps
module tb_bounded_denominator_rational_approx_core;
  import bdra_pkg::*;

  localparam int unsigned IN_W = ((FRAC_BITS_DEF + 1 + DENOM_BITS_DEF + 7) / 8) * 8;
  localparam logic [FRAC_BITS_DEF:0] ONE_Q = 33'h1_0000_0000;
  localparam int unsigned RANDOM_WORDS = 100;
  localparam int unsigned CALM_WORDS   = 20;
  localparam int unsigned LONG_HOLD    = 400;
  // slowest word walks up to 65534 mediant steps with no handshake; STALL_LIMIT quiet cycles count as a hang
  localparam int unsigned STALL_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned mismatch_count, fractions_owed, fractions_seen;
  int unsigned words_sent;
  int unsigned quiet_cycles;
  bit          idling_on;
  bit          long_hold_req;

  always #6 clk_i = ~clk_i;

  bounded_denominator_rational_approx_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bdra_checker #(.IN_W(IN_W)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .fractions_owed_o (fractions_owed),
    .fractions_seen_o (fractions_seen)
  );

  // offer one word, maybe after a random gap, and wait for its handshake
  task automatic send_word(input logic [FRAC_BITS_DEF:0] x,
                           input logic [DENOM_BITS_DEF-1:0] n);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'({n, x});
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  // mostly well-formed values in range, some errors and exact ends
  task automatic send_random_word();
    logic [FRAC_BITS_DEF:0]  x;
    logic [DENOM_BITS_DEF-1:0] n;
    logic [15:0]             fp, fq;
    int unsigned             kind, pick;
    kind = $urandom_range(0, 99);
    if (kind < 4) begin
      x = {1'b1, 32'($urandom)};
      if (x == ONE_Q) x = ONE_Q + 1;
      n = 16'($urandom);
    end else if (kind < 8) begin
      x = {1'b0, 32'($urandom)};
      n = '0;
    end else if (kind < 12) begin
      x = (kind < 10) ? '0 : ONE_Q;
      n = 16'($urandom_range(1, 65535));
    end else begin
      if (kind < 30) begin
        // near a simple fraction, so the walk can stop on the error bound
        fq = 16'($urandom_range(2, 64));
        fp = 16'($urandom_range(1, fq - 1));
        x  = 33'((64'(fp) << FRAC_BITS_DEF) / fq) + 33'($urandom_range(0, 2)) - 33'd1;
      end else begin
        x = {1'b0, 32'($urandom)};
        if (x == 0) x = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 60)      n = 16'($urandom_range(1, 64));
      else if (pick < 92) n = 16'($urandom_range(65, 2048));
      else                n = 16'($urandom_range(2049, 65535));
    end
    send_word(x, n);
  endtask

  // result side: random stall bursts, one long hold to back up the core
  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // hang guard: cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset, directed words, random words, drain and verdict
  initial begin
    int unsigned i;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    idling_on     = 1'b1;
    long_hold_req = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // exact ends, error codes and their precedence
    send_word('0, 16'd1);
    send_word('0, 16'hFFFF);
    send_word(ONE_Q, 16'd1);
    send_word(ONE_Q, 16'hFFFF);
    send_word(ONE_Q + 1, 16'd5);
    send_word(33'h1_FFFF_FFFF, 16'd0);
    send_word(33'h0_5555_5555, 16'd0);
    // order one: below, above and exactly at one half (tie keeps 0/1)
    send_word(33'h0_4CCC_CCCD, 16'd1);
    send_word(33'h0_B333_3333, 16'd1);
    send_word(33'h0_8000_0000, 16'd1);
    // tie between 1/2 and 1/1 at three quarters
    send_word(33'h0_C000_0000, 16'd2);
    // exact mediant hit, near two thirds, alternating bit patterns
    send_word(33'h0_8000_0000, 16'hFFFF);
    send_word(33'h0_AAAA_AAAA, 16'hFFFF);
    send_word(33'h0_5555_5555, 16'h5555);
    send_word(33'h0_AAAA_AAAA, 16'hAAAA);
    send_word(33'd608135816, 16'd1000);
    // smallest and largest value below one, long walks
    send_word(33'd1, 16'd3);
    send_word(33'h0_FFFF_FFFF, 16'd1);
    send_word(33'h0_FFFF_FFFF, 16'd4096);
    send_word(33'd1, 16'hFFFF);

    // back up the core while words keep coming
    long_hold_req = 1'b1;
    for (i = 0; i < RANDOM_WORDS; i++) begin
      idling_on = (i < RANDOM_WORDS - CALM_WORDS);
      send_random_word();
    end
    s_axis_tvalid <= 1'b0;

    // let the checker log the last word before watching the owed count
    @(posedge clk_i);
    while (fractions_owed != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run sent %0d words (directed extremes, errors, ties, long walks, random) ",
             words_sent);
    $display("and checked %0d result words field by field", fractions_seen);
    if (mismatch_count == 0 && fractions_owed == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/bdra_pkg.sv
rtl/core/bdra_alu.sv
rtl/core/bdra_seq.sv
rtl/core/bounded_denominator_rational_approx_core.sv
sim/bdra_checker.sv
sim/tb_bounded_denominator_rational_approx_core.sv
